### rtl/q2e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_pkg
// shared constants for the quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package q2e_pkg;

    // fractional bits of the angle accumulator (degrees)
    localparam int ANG_FRAC = 20;

    // arctangent table, degrees with ANG_FRAC fractional bits
    function automatic logic signed [31:0] f_atan_deg(input int i);
        logic signed [31:0] v;
        case (i)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            20: v = 32'sd57;
            21: v = 32'sd29;
            22: v = 32'sd14;
            23: v = 32'sd7;
            24: v = 32'sd4;
            25: v = 32'sd2;
            26: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/quaternion_to_euler_angles_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// quaternion to zyx euler angles, fully pipelined vectoring cordic
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | tdata: quat_c0, quat_c1, quat_c2, quat_c3
//  m_axis   | out | tdata: psi_deg, theta_deg, phi_deg; tuser: domain_clamped
//
//  one beat in and one beat out per cycle while the output is not stalled
//  the pipeline holds five front stages, 29 square root stages (one root
//  bit each), the cordic entry stage, one stage per cordic rotation and
//  the output register
//  the whole pipeline advances together; a stall at the output freezes it
//  and holds the input off while a result waits
//  synchronous active-low reset clears valid bits only
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
#(
    parameter int IN_WIDTH      = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // quat_c0, quat_c1, quat_c2, quat_c3 from the lowest bit
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // psi_deg, theta_deg, phi_deg from the lowest bit
    output logic [((3*ANGLE_WIDTH-1+7)/8)*8-1:0] m_axis_tdata,
    // domain_clamped
    output logic                         m_axis_tuser
);

    localparam int OW   = ANGLE_WIDTH;
    localparam int ODW  = ((3*ANGLE_WIDTH-1+7)/8)*8;
    localparam int SH   = 2*IN_WIDTH - 32;      // product shift to q28
    localparam int PW   = 2*IN_WIDTH;           // raw product width
    localparam int QW   = 40;                   // q28 sums, |v| < 2^35
    localparam int CW   = 58;                   // cordic x/y width
    localparam int ZW   = 32;                   // angle accumulator width
    localparam int NB   = 29;                   // sqrt stages, one root bit each
    localparam int NC   = CORDIC_STAGES;
    localparam int NST  = 5 + NB + 1 + NC;      // pipeline stages before the output register
    localparam int OF   = ANGLE_WIDTH - 9;

    // global advance: pipeline moves when output register is free
    logic w_adv;
    logic r_out_valid;
    assign w_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;

    logic [NST-1:0] r_vld;

    // ---------------- stage 0: register inputs
    logic signed [IN_WIDTH-1:0] r_c0, r_c1, r_c2, r_c3;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c0 <= s_axis_tdata[0*IN_WIDTH +: IN_WIDTH];
            r_c1 <= s_axis_tdata[1*IN_WIDTH +: IN_WIDTH];
            r_c2 <= s_axis_tdata[2*IN_WIDTH +: IN_WIDTH];
            r_c3 <= s_axis_tdata[3*IN_WIDTH +: IN_WIDTH];
        end
    end

    // ---------------- stage 1: nine products at q28
    function automatic logic signed [QW-1:0] f_q28(input logic signed [PW-1:0] p);
        logic signed [QW+PW-1:0] e;
        e = (QW+PW)'(p);
        if (SH >= 0) return QW'(e >>> SH);
        return QW'(e <<< (-SH));
    endfunction

    logic signed [QW-1:0] r_p00, r_p11, r_p33, r_p01, r_p02, r_p03, r_p12, r_p13, r_p23;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p00 <= f_q28(r_c0 * r_c0);
            r_p11 <= f_q28(r_c1 * r_c1);
            r_p33 <= f_q28(r_c3 * r_c3);
            r_p01 <= f_q28(r_c0 * r_c1);
            r_p02 <= f_q28(r_c0 * r_c2);
            r_p03 <= f_q28(r_c0 * r_c3);
            r_p12 <= f_q28(r_c1 * r_c2);
            r_p13 <= f_q28(r_c1 * r_c3);
            r_p23 <= f_q28(r_c2 * r_c3);
        end
    end

    // ---------------- stage 2: sums and clamp
    localparam logic signed [QW-1:0] ONE28 = QW'(64'sd1 << 28);
    logic signed [QW-1:0] r_py, r_px, r_fy, r_fx, r_s;
    logic                 r_clamp2;
    logic signed [QW-1:0] w_s;
    assign w_s = 2*r_p13 + 2*r_p02;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_py <= 2*r_p12 - 2*r_p03;
            r_px <= 2*r_p00 + 2*r_p11 - ONE28;
            r_fy <= 2*r_p23 - 2*r_p01;
            r_fx <= 2*r_p00 + 2*r_p33 - ONE28;
            if (w_s > ONE28) begin
                r_s <= ONE28; r_clamp2 <= 1'b1;
            end else if (w_s < -ONE28) begin
                r_s <= -ONE28; r_clamp2 <= 1'b1;
            end else begin
                r_s <= w_s; r_clamp2 <= 1'b0;
            end
        end
    end

    // ---------------- stage 3: square of s (29x29 multiply)
    logic signed [QW-1:0] r_py3, r_px3, r_fy3, r_fx3, r_s3;
    logic                 r_clamp3;
    logic [28:0]          w_as;
    logic [57:0]          r_rad3;
    assign w_as = r_s[QW-1] ? 29'(-r_s) : 29'(r_s);
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_py3 <= r_py; r_px3 <= r_px; r_fy3 <= r_fy; r_fx3 <= r_fx;
            r_s3 <= r_s; r_clamp3 <= r_clamp2;
            r_rad3 <= w_as * w_as;
        end
    end

    // square root pipeline entry (radicand < 2^58)
    typedef struct packed {
        logic [57:0] rem;
        logic [28:0] root;
        logic signed [QW-1:0] py, px, fy, fx, s;
        logic clamp;
    } t_sq;

    t_sq r_sq [NB+1];

    // ---------------- stage 4: radicand 2^56 - s^2
    t_sq n_sq0;
    always_comb begin
        n_sq0.rem   = (58'd1 << 56) - r_rad3;
        n_sq0.root  = '0;
        n_sq0.py    = r_py3;
        n_sq0.px    = r_px3;
        n_sq0.fy    = r_fy3;
        n_sq0.fx    = r_fx3;
        n_sq0.s     = r_s3;
        n_sq0.clamp = r_clamp3;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq[0] <= n_sq0;
        end
    end

    // ---------------- square root stages, one result bit per stage
    // restoring integer square root, bit k from the top
    for (genvar k = 0; k < NB; k++) begin : g_sq
        localparam int B = NB - 1 - k;
        logic [59:0] w_trial;
        t_sq         n_sq;
        assign w_trial = ({31'd0, r_sq[k].root} << (B + 1)) + (60'd1 << (2*B));
        always_comb begin
            n_sq = r_sq[k];
            if ({2'b0, r_sq[k].rem} >= w_trial) begin
                n_sq.rem  = 58'({2'b0, r_sq[k].rem} - w_trial);
                n_sq.root = r_sq[k].root | (29'd1 << B);
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_sq[k+1] <= n_sq;
            end
        end
    end

    // ---------------- three cordic lanes in lockstep
    typedef struct packed {
        logic signed [CW-1:0] x, y;
        logic signed [ZW-1:0] z;
    } t_cv;
    typedef struct packed {
        t_cv  a, b, c;
        logic clamp;
    } t_cl;

    function automatic t_cv f_pre(input logic signed [QW-1:0] y0, input logic signed [QW-1:0] x0);
        t_cv r;
        logic signed [CW-1:0] x, y;
        x = CW'(x0) <<< ANG_FRAC;
        y = CW'(y0) <<< ANG_FRAC;
        r.z = '0;
        r.x = x; r.y = y;
        if (x < 0) begin
            if (y >= 0) begin
                r.x = y; r.y = -x; r.z = ZW'(90 <<< ANG_FRAC);
            end else begin
                r.x = -y; r.y = x; r.z = -ZW'(90 <<< ANG_FRAC);
            end
        end
        return r;
    endfunction

    function automatic t_cv f_rot(input t_cv v, input int i);
        t_cv r;
        logic signed [CW-1:0] xs, ys;
        xs = v.x >>> i;
        ys = v.y >>> i;
        if (v.y >= 0) begin
            r.x = v.x + ys; r.y = v.y - xs; r.z = v.z + ZW'(f_atan_deg(i));
        end else begin
            r.x = v.x - ys; r.y = v.y + xs; r.z = v.z - ZW'(f_atan_deg(i));
        end
        return r;
    endfunction

    // zero-input detect travels as its own bit per lane
    t_cl r_cl [NC+1];
    logic [2:0] r_zero [NC+1];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cl[0] <= '{a: f_pre(r_sq[NB].py, r_sq[NB].px),
                         b: f_pre(r_sq[NB].s, QW'({11'd0, r_sq[NB].root})),
                         c: f_pre(r_sq[NB].fy, r_sq[NB].fx),
                         clamp: r_sq[NB].clamp};
            r_zero[0] <= {r_sq[NB].fy == 0 && r_sq[NB].fx == 0,
                          r_sq[NB].s == 0 && r_sq[NB].root == 0,
                          r_sq[NB].py == 0 && r_sq[NB].px == 0};
        end
    end
    for (genvar i = 0; i < NC; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cl[i+1] <= '{a: f_rot(r_cl[i].a, i),
                               b: f_rot(r_cl[i].b, i),
                               c: f_rot(r_cl[i].c, i),
                               clamp: r_cl[i].clamp};
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // ---------------- output rounding and saturation
    function automatic logic signed [OW-1:0] f_out(input logic signed [ZW-1:0] z,
                                                  input int lim_deg);
        logic signed [63:0] v, lim;
        if (OF <= ANG_FRAC) begin
            if (ANG_FRAC - OF > 0)
                v = (64'(z) + (64'sd1 <<< (ANG_FRAC - OF - 1))) >>> (ANG_FRAC - OF);
            else
                v = 64'(z);
        end else begin
            v = 64'(z) <<< (OF - ANG_FRAC);
        end
        lim = 64'(lim_deg) <<< OF;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return OW'(v);
    endfunction

    logic signed [ZW-1:0] w_za, w_zb, w_zc;
    assign w_za = r_zero[NC][0] ? '0 : r_cl[NC].a.z;
    assign w_zb = r_zero[NC][1] ? '0 : -r_cl[NC].b.z;
    assign w_zc = r_zero[NC][2] ? '0 : r_cl[NC].c.z;

    logic [OW-1:0]   w_psi, w_th, w_phi;
    assign w_psi = f_out(w_za, 180);
    assign w_th  = f_out(w_zb, 90);
    assign w_phi = f_out(w_zc, 180);

    logic [ODW-1:0] r_odata;
    logic           r_ouser;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_odata <= ODW'({w_phi, w_th[OW-2:0], w_psi});
            r_ouser <= r_cl[NC].clamp;
        end
    end

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[NST-2:0], s_axis_tvalid};
            r_out_valid <= r_vld[NST-1];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

### rtl/q2e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_sva
// port-level checks of the quaternion to euler pipeline
// ----------------------------------------------------------------------------
module q2e_sva (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic m_axis_tuser
);

    // a stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tuser))
        else $error("output beat dropped under stall");

    // input is open whenever output is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // stalled output blocks input
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during stall");

    // no output after reset without input
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind quaternion_to_euler_angles_top q2e_sva u_q2e_sva (.*);

### tb/q2e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2e_checker
// watches both stream channels, predicts the euler angles of every accepted
// quaternion beat and compares each output beat with the oldest prediction
// ----------------------------------------------------------------------------
module q2e_checker
    import q2e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // quat_c0, quat_c1, quat_c2, quat_c3 from the lowest bit
    input  logic [63:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // psi_deg, theta_deg, phi_deg from the lowest bit
    input  logic [47:0] i_m_tdata,
    // domain_clamped
    input  logic        i_m_tuser,
    output int          o_errors,
    output int          o_pending
);

    localparam int STAGES = 16;
    localparam longint ONE_Q28 = 64'sd1 << 28;

    typedef struct packed {
        logic [15:0] psi;
        logic [14:0] theta;
        logic [15:0] phi;
        logic        clamped;
    } t_angles;

    t_angles angle_q[$];

    // exact floor square root
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // vectoring cordic, degrees with 20 fractional bits
    function automatic longint atan2_deg(input longint y_in, input longint x_in);
        longint x, y, z, t, xs, ys;
        if (x_in == 0 && y_in == 0) return 0;
        x = x_in <<< ANG_FRAC;
        y = y_in <<< ANG_FRAC;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 64'sd90 <<< ANG_FRAC;
            end else begin
                x = -y; y = t; z = -(64'sd90 <<< ANG_FRAC);
            end
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + longint'(f_atan_deg(i));
            end else begin
                x = x - ys; y = y + xs; z = z - longint'(f_atan_deg(i));
            end
        end
        return z;
    endfunction

    // round half up to 7 fractional bits and saturate
    function automatic longint deg_q7(input longint z, input longint lim_deg);
        longint v, lim;
        v = (z + 64'sd4096) >>> 13;
        lim = lim_deg * 128;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v;
    endfunction

    function automatic t_angles euler_of(input logic [63:0] d);
        longint c0, c1, c2, c3, s, c;
        longint v_psi, v_theta, v_phi;
        t_angles a;
        c0 = longint'($signed(d[15:0]));
        c1 = longint'($signed(d[31:16]));
        c2 = longint'($signed(d[47:32]));
        c3 = longint'($signed(d[63:48]));
        v_psi = atan2_deg(2*c1*c2 - 2*c0*c3, 2*c0*c0 + 2*c1*c1 - ONE_Q28);
        v_phi = atan2_deg(2*c2*c3 - 2*c0*c1, 2*c0*c0 + 2*c3*c3 - ONE_Q28);
        s = 2*c1*c3 + 2*c0*c2;
        a.clamped = 1'b0;
        // asin argument outside the unit range
        if (s > ONE_Q28) begin
            s = ONE_Q28; a.clamped = 1'b1;
        end
        if (s < -ONE_Q28) begin
            s = -ONE_Q28; a.clamped = 1'b1;
        end
        c = longint'(isqrt(longint'(ONE_Q28 * ONE_Q28) - s * s));
        v_theta = -atan2_deg(s, c);
        v_psi = deg_q7(v_psi, 180);
        v_theta = deg_q7(v_theta, 90);
        v_phi = deg_q7(v_phi, 180);
        a.psi = v_psi[15:0];
        a.theta = v_theta[14:0];
        a.phi = v_phi[15:0];
        return a;
    endfunction

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_angles want, got;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                angle_q.insert(angle_q.size(), euler_of(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.psi = i_m_tdata[15:0];
                got.theta = i_m_tdata[30:16];
                got.phi = i_m_tdata[46:31];
                got.clamped = i_m_tuser;
                if (angle_q.size() == 0) begin
                    if (o_errors < 10) $display("q2e_checker: output beat with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = angle_q.pop_front();
                    if (want !== got) begin
                        if (o_errors < 10)
                            $display({"q2e_checker: mismatch psi %h/%h theta %h/%h",
                                      " phi %h/%h clamp %b/%b"},
                                     want.psi, got.psi, want.theta, got.theta,
                                     want.phi, got.phi, want.clamped, got.clamped);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= angle_q.size();
    end
endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random quaternion beats with random gaps and output
// stalls, and reports the verdict from the checker's error and pending counts
// ----------------------------------------------------------------------------
module tb_top;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // quat_c0, quat_c1, quat_c2, quat_c3 from the lowest bit
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // psi_deg, theta_deg, phi_deg from the lowest bit
    logic [47:0] m_axis_tdata;
    // domain_clamped
    logic        m_axis_tuser;
    int          errors;
    int          pending;
    int          idle_cycles = 0;
    bit          quiet_mode = 0;

    always #10 i_clk = ~i_clk;

    quaternion_to_euler_angles_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    q2e_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_m_tuser(m_axis_tuser), .o_errors(errors), .o_pending(pending)
    );

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output stall pattern
    always @(posedge i_clk) begin
        int stall;
        if (stall > 0) begin
            stall = stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall = gap_len();
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic send_quat(input logic [15:0] c0, c1, c2, c3);
        int g;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {c3, c2, c1, c0};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] q0, q1, q2, q3;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity, zero and extreme components
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // asin argument near plus and minus one (gimbal lock)
        send_quat(16'sd11585, 0, 16'sd11585, 0);
        send_quat(16'sd11585, 0, -16'sd11585, 0);
        send_quat(16'sd11586, 0, 16'sd11586, 0);
        // asin argument clamped on both sides
        send_quat(16'h7fff, 0, 16'h7fff, 0);
        send_quat(16'h7fff, 0, 16'h8000, 0);
        send_quat(0, 16'h7fff, 0, 16'h7fff);
        // both psi operands zero
        send_quat(16'sd8192, 16'sd8192, 0, 0);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        // both phi operands zero
        send_quat(16'sd8192, 0, 0, 16'sd8192);
        // half turns about each axis, negated identity and quarter turns
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(-16'sd16384, 0, 0, 0);
        send_quat(16'sd11585, 16'sd11585, 0, 0);
        send_quat(16'sd11585, 0, 0, -16'sd11585);

        // random part, mostly near unit magnitude
        for (int n = 0; n < 400; n++) begin
            if (n % 60 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0) begin
                q0 = 16'($urandom); q1 = 16'($urandom);
                q2 = 16'($urandom); q3 = 16'($urandom);
            end else begin
                q0 = 16'($signed($urandom_range(0, 20000)) - 10000);
                q1 = 16'($signed($urandom_range(0, 20000)) - 10000);
                q2 = 16'($signed($urandom_range(0, 20000)) - 10000);
                q3 = 16'($signed($urandom_range(0, 20000)) - 10000);
            end
            send_quat(q0, q1, q2, q3);
        end
        s_axis_tvalid <= 1'b0;
        quiet_mode = 0;

        // drain
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
